// ===== hw/rtl/kst_pkg.sv =====
// ----------------------------------------------------------------------------
// kst_pkg
// Types, constants and helpers shared by the keyed segment table.
// ----------------------------------------------------------------------------
package kst_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int SLOT_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam int KEY_W      = 32;
  localparam int SIZE_W     = 32;
  localparam int STATUS_W   = 3;
  localparam int SEG_IDX_W  = 4;
  localparam int CFG_ADDR_W = 8;
  localparam int CFG_DATA_W = 32;

  localparam int QUEUE_DEPTH = 2;
  localparam int QP_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_ADDR_W-1:0] REG_MIN_SIZE = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_SIZE = CFG_ADDR_W'(1);

  localparam logic [SIZE_W-1:0] MIN_SIZE_RST = SIZE_W'(1);
  localparam logic [SIZE_W-1:0] MAX_SIZE_RST = SIZE_W'(4194304);

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_EXISTS    = 3'd2,
    ST_INVALID   = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  // Request class, decided at the front
  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_OPEN   = 2'd1,
    OP_EXCL   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE    = 2'd0,
    BK_MATCH   = 2'd1,
    BK_RESOLVE = 2'd2
  } back_state_t;

  typedef struct packed {
    logic [KEY_W-1:0]  seg_key;
    logic [SIZE_W-1:0] req_size;
    op_t               op;
  } req_t;

  // Index of the lowest set bit; 0 when none is set
  function automatic logic [SLOT_W-1:0] lowest_set(input logic [TABLE_ENTRIES-1:0] vec);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = SLOT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== hw/rtl/kst_front.sv =====
// ----------------------------------------------------------------------------
// kst_front
// Accepts request words, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module kst_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [kst_pkg::KEY_W-1:0]  in_seg_key,
  input  logic [kst_pkg::SIZE_W-1:0] in_req_size,
  input  logic                       in_create,
  input  logic                       in_exclusive,
  output logic                       q_valid,
  output kst_pkg::req_t              q_req,
  input  logic                       q_pop
);
  import kst_pkg::*;

  req_t             q_mem [QUEUE_DEPTH];
  logic [QP_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QP_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0]  count_r, count_nxt;
  logic             push;
  req_t             new_req;

  // create wins over exclusive
  always_comb begin
    new_req.seg_key  = in_seg_key;
    new_req.req_size = in_req_size;
    if (in_create) begin
      new_req.op = OP_OPEN;
    end else if (in_exclusive) begin
      new_req.op = OP_EXCL;
    end else begin
      new_req.op = OP_LOOKUP;
    end
  end

  assign in_stall = (count_r == QC_W'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign q_req    = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QP_W'(1);
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QP_W'(1);
    end
    if (push && !q_pop) begin
      count_nxt = count_r + QC_W'(1);
    end else if (!push && q_pop) begin
      count_nxt = count_r - QC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= new_req;
    end
  end

endmodule

// ===== hw/rtl/kst_table.sv =====
// ----------------------------------------------------------------------------
// kst_table
// Slot table engine: parallel key compare, then resolve, update and result.
// ----------------------------------------------------------------------------
module kst_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  kst_pkg::req_t                 q_req,
  output logic                          q_pop,
  input  logic [kst_pkg::SIZE_W-1:0]    min_size,
  input  logic [kst_pkg::SIZE_W-1:0]    max_size,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [kst_pkg::STATUS_W-1:0]  out_status,
  output logic [kst_pkg::SEG_IDX_W-1:0] out_seg_index
);
  import kst_pkg::*;

  back_state_t                state_r, state_nxt;
  req_t                       req_r;
  logic [TABLE_ENTRIES-1:0]   hit_r;
  logic [TABLE_ENTRIES-1:0]   free_r;
  logic [TABLE_ENTRIES-1:0]   slot_used_r;
  logic [KEY_W-1:0]           slot_key_r  [TABLE_ENTRIES];
  logic [SIZE_W-1:0]          slot_size_r [TABLE_ENTRIES];

  logic                       out_valid_r, out_valid_nxt;
  status_t                    out_status_r;
  logic [SEG_IDX_W-1:0]       out_seg_index_r;

  logic                       take;
  logic                       out_free;
  logic                       finish;
  logic                       hit_any, free_any, size_ok;
  logic [SLOT_W-1:0]          hit_idx, free_idx, res_slot;
  status_t                    res_status;
  logic                       do_store;
  logic [SLOT_W+SEG_IDX_W-1:0] idx_wide;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    take      = 1'b0;
    finish    = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          take      = 1'b1;
          state_nxt = BK_MATCH;
        end
      end
      BK_MATCH: begin
        state_nxt = BK_RESOLVE;
      end
      BK_RESOLVE: begin
        if (out_free) begin
          finish = 1'b1;
          if (q_valid) begin
            take      = 1'b1;
            state_nxt = BK_MATCH;
          end else begin
            state_nxt = BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  assign q_pop = take;

  // Resolve the registered compare vectors
  assign hit_any  = |hit_r;
  assign free_any = |free_r;
  assign hit_idx  = lowest_set(hit_r);
  assign free_idx = lowest_set(free_r);
  assign size_ok  = (req_r.req_size >= min_size) && (req_r.req_size <= max_size);

  always_comb begin
    res_status = ST_OK;
    res_slot   = '0;
    do_store   = 1'b0;
    if (hit_any && req_r.op == OP_LOOKUP) begin
      res_slot = hit_idx;
    end else if (hit_any && req_r.op == OP_OPEN) begin
      if (req_r.req_size > slot_size_r[hit_idx]) begin
        res_status = ST_INVALID;
      end else begin
        res_slot = hit_idx;
      end
    end else if (hit_any && req_r.op == OP_EXCL) begin
      res_status = ST_EXISTS;
    end else begin
      case (req_r.op)
        OP_OPEN, OP_EXCL: begin
          if (!free_any) begin
            res_status = ST_FULL;
          end else if (!size_ok) begin
            res_status = ST_INVALID;
          end else begin
            res_slot = free_idx;
            do_store = 1'b1;
          end
        end
        default: begin
          res_status = ST_NOT_FOUND;
        end
      endcase
    end
  end

  assign idx_wide = {{SEG_IDX_W{1'b0}}, res_slot};

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (finish) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      slot_used_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (finish && do_store) begin
        slot_used_r[free_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      req_r <= q_req;
    end
    if (state_r == BK_MATCH) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        hit_r[i]  <= slot_used_r[i] && (slot_key_r[i] == req_r.seg_key);
        free_r[i] <= !slot_used_r[i];
      end
    end
    if (finish) begin
      out_status_r    <= res_status;
      out_seg_index_r <= (res_status == ST_OK) ? idx_wide[SEG_IDX_W-1:0] : '0;
      if (do_store) begin
        slot_key_r[free_idx]  <= req_r.seg_key;
        slot_size_r[free_idx] <= req_r.req_size;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_seg_index = out_seg_index_r;

endmodule

// ===== hw/rtl/keyed_segment_table.sv =====
// ----------------------------------------------------------------------------
// keyed_segment_table
// Table of shared segment slots: lookup, create and exclusive create by key.
// ----------------------------------------------------------------------------
// Usage:
//   Request words enter on in_valid / in_stall (seg_key, req_size, create,
//   exclusive); a word is taken on a clock edge with in_valid high and
//   in_stall low. Each request yields exactly one result word on out_valid /
//   out_stall (status, seg_index), in request order.
//   Limits min_size and max_size are written on the cfg port (index 0 and 1,
//   taken when cfg_valid and cfg_ready are high); cfg_ready is always high.
//   Write them only while the block is idle.
//   A request taken passes the queue, the compare state and the resolve
//   state before its result word is registered. The engine handles one
//   request at a time: a parallel key compare over all slots, then resolve
//   and update the slot; a new request is taken only when the last finishes.
//   A two-word queue in front absorbs requests while the engine or the
//   output is busy; in_stall rises when it is full. A stalled result stays
//   in the output register while the engine finishes the next compare.
//   Reset empties the table and the queue and restores the default limits.
// ----------------------------------------------------------------------------
module keyed_segment_table (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [kst_pkg::KEY_W-1:0]      in_seg_key,
  input  logic [kst_pkg::SIZE_W-1:0]     in_req_size,
  input  logic                           in_create,
  input  logic                           in_exclusive,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [kst_pkg::STATUS_W-1:0]   out_status,
  output logic [kst_pkg::SEG_IDX_W-1:0]  out_seg_index,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [kst_pkg::CFG_ADDR_W-1:0] cfg_index,
  input  logic [kst_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import kst_pkg::*;

  logic [SIZE_W-1:0] min_size_r;
  logic [SIZE_W-1:0] max_size_r;
  logic              q_valid;
  req_t              q_req;
  logic              q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_size_r <= MIN_SIZE_RST;
      max_size_r <= MAX_SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_MIN_SIZE) begin
        min_size_r <= cfg_wdata;
      end else if (cfg_index == REG_MAX_SIZE) begin
        max_size_r <= cfg_wdata;
      end
    end
  end

  kst_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_seg_key   (in_seg_key),
    .in_req_size  (in_req_size),
    .in_create    (in_create),
    .in_exclusive (in_exclusive),
    .q_valid      (q_valid),
    .q_req        (q_req),
    .q_pop        (q_pop)
  );

  kst_table u_table (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_req         (q_req),
    .q_pop         (q_pop),
    .min_size      (min_size_r),
    .max_size      (max_size_r),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_seg_index (out_seg_index)
  );

`ifndef SYNTHESIS
  // Non-ok results never carry a slot
  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_seg_index == '0))
    else $error("non-ok result carries a slot index");

  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid after reset");

  a_rst_in: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("request queue not empty after reset");

  // The engine only pops a word that is there
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");
`endif

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the keyed segment table: directed lookups, opens and
// exclusive creates at the size limits, then random traffic over a small key
// pool under three idle mixes and one long output hold-off. A shadow table
// predicts every result word, which is checked in order as it leaves.
// ----------------------------------------------------------------------------
module testbench;
  import kst_pkg::*;

  localparam int KEY_POOL    = 24;
  localparam int HOLD_CYCLES = 48;
  localparam int RAND_ITEMS  = 300;  // per idle mix
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_LO = CFG_ADDR_W'(2);
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_HI = CFG_ADDR_W'(255);

  typedef struct packed {
    status_t                status;
    logic [SEG_IDX_W-1:0]   index;
  } reply_t;

  // Shadow of the slot table plus the queue of result words still owed
  class seg_table_shadow;
    bit                 used  [TABLE_ENTRIES];
    logic [KEY_W-1:0]   keys  [TABLE_ENTRIES];
    logic [SIZE_W-1:0]  sizes [TABLE_ENTRIES];
    logic [SIZE_W-1:0]  lo_limit;
    logic [SIZE_W-1:0]  hi_limit;
    reply_t             replies_due[$];
    int                 errors;
    int                 checked;
    int                 per_status[5];

    function new();
      lo_limit = MIN_SIZE_RST;
      hi_limit = MAX_SIZE_RST;
      foreach (used[i]) used[i] = 1'b0;
      errors  = 0;
      checked = 0;
      foreach (per_status[i]) per_status[i] = 0;
    endfunction

    function void set_limit(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_MIN_SIZE) lo_limit = val;
      else if (idx == REG_MAX_SIZE) hi_limit = val;
    endfunction

    // Full table is reported ahead of the size check
    function status_t claim_slot(logic [KEY_W-1:0] key, logic [SIZE_W-1:0] size,
                                 output logic [SEG_IDX_W-1:0] idx);
      int free_slot;
      free_slot = -1;
      idx = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (!used[i] && free_slot < 0) free_slot = i;
      end
      if (free_slot < 0) return ST_FULL;
      if (size < lo_limit || size > hi_limit) return ST_INVALID;
      used[free_slot]  = 1'b1;
      keys[free_slot]  = key;
      sizes[free_slot] = size;
      idx = SEG_IDX_W'(free_slot);
      return ST_OK;
    endfunction

    function void note_request(logic [KEY_W-1:0] key, logic [SIZE_W-1:0] size,
                               bit create, bit excl);
      int     hit;
      reply_t r;
      hit = -1;
      r.index = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (used[i] && keys[i] == key && hit < 0) hit = i;
      end
      if (create) begin
        if (hit >= 0) begin
          if (size > sizes[hit]) begin
            r.status = ST_INVALID;
          end else begin
            r.status = ST_OK;
            r.index  = SEG_IDX_W'(hit);
          end
        end else begin
          r.status = claim_slot(key, size, r.index);
        end
      end else if (excl) begin
        if (hit >= 0) r.status = ST_EXISTS;
        else r.status = claim_slot(key, size, r.index);
      end else if (hit >= 0) begin
        r.status = ST_OK;
        r.index  = SEG_IDX_W'(hit);
      end else begin
        r.status = ST_NOT_FOUND;
      end
      replies_due.push_back(r);
    endfunction

    function void check_reply(logic [STATUS_W-1:0] status, logic [SEG_IDX_W-1:0] index);
      reply_t r;
      if (replies_due.size() == 0) begin
        $display("%0t: result word with none expected: status %0d index %0d",
                 $time, status, index);
        errors++;
        return;
      end
      r = replies_due.pop_front();
      checked++;
      if (int'(r.status) < 5) per_status[int'(r.status)]++;
      if (status !== r.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d", $time, r.status, status);
        errors++;
      end
      if (index !== r.index) begin
        $display("%0t: seg_index mismatch: expected %0d actual %0d", $time, r.index, index);
        errors++;
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n         = 1'b0;
  logic                    in_valid      = 1'b0;
  logic                    in_stall;
  logic [KEY_W-1:0]        in_seg_key    = '0;
  logic [SIZE_W-1:0]       in_req_size   = '0;
  logic                    in_create     = 1'b0;
  logic                    in_exclusive  = 1'b0;
  logic                    out_valid;
  logic                    out_stall     = 1'b1;
  logic [STATUS_W-1:0]     out_status;
  logic [SEG_IDX_W-1:0]    out_seg_index;
  logic                    cfg_valid     = 1'b0;
  logic                    cfg_ready;
  logic [CFG_ADDR_W-1:0]   cfg_index     = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata     = '0;

  seg_table_shadow         sb;
  int                      send_idle_pct = 0;
  int                      recv_idle_pct = 0;
  int                      hold_asked    = 0;
  int                      hold_served   = 0;
  int                      requests_sent = 0;
  logic [KEY_W-1:0]        key_pool[KEY_POOL];

  keyed_segment_table DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_seg_key    (in_seg_key),
    .in_req_size   (in_req_size),
    .in_create     (in_create),
    .in_exclusive  (in_exclusive),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_seg_index (out_seg_index),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // Result side: random stall, or a long hold-off when one is asked for
  initial begin : result_sink
    int left;
    left = 0;
    forever begin
      @(negedge clk);
      if (left > 0) begin
        out_stall <= 1'b1;
        left--;
      end else if (hold_served != hold_asked) begin
        hold_served++;
        left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_reply(out_status, out_seg_index);
  end

  task automatic send_request(input logic [KEY_W-1:0] key, input logic [SIZE_W-1:0] size,
                              input bit create, input bit excl);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_seg_key   <= key;
    in_req_size  <= size;
    in_create    <= create;
    in_exclusive <= excl;
    do @(posedge clk); while (in_stall);
    sb.note_request(key, size, create, excl);
    requests_sent++;
  endtask

  // Sizes lean on the current limits so creations hit both sides of them
  task automatic send_random_request();
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] size;
    int                pick;
    pick = $urandom_range(0, 99);
    key  = (pick < 75) ? key_pool[$urandom_range(0, KEY_POOL - 1)] : KEY_W'($urandom());
    pick = $urandom_range(0, 99);
    if (pick < 3)       size = sb.lo_limit;
    else if (pick < 6)  size = sb.hi_limit;
    else if (pick < 12) size = sb.lo_limit - 1;
    else if (pick < 18) size = sb.hi_limit + 1;
    else if (pick < 25) size = SIZE_W'($urandom_range(0, 3));
    else                size = SIZE_W'($urandom());
    send_request(key, size, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic write_limit(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_limit(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop in_valid and wait for every owed word
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.replies_due.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    sb = new();
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = KEY_W'($urandom());

    send_idle_pct = 33;
    recv_idle_pct = 88;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset limits, open versus exclusive, existing keys
    send_request(32'h0000_0000, 32'd0,       1'b0, 1'b0);
    send_request(32'h0000_0000, 32'd0,       1'b1, 1'b0);
    send_request(32'h0000_0000, 32'd4194305, 1'b1, 1'b0);
    send_request(32'h0000_0000, 32'd1,       1'b1, 1'b0);
    send_request(32'h0000_0000, 32'd1,       1'b1, 1'b0);
    send_request(32'h0000_0000, 32'd2,       1'b1, 1'b0);
    send_request(32'h0000_0000, 32'd1,       1'b0, 1'b1);
    send_request(32'h0000_0000, 32'd1,       1'b1, 1'b1);
    send_request(32'hFFFF_FFFF, 32'd4194304, 1'b0, 1'b1);
    send_request(32'hFFFF_FFFF, 32'd0,       1'b0, 1'b0);
    send_request(32'h0001_2345, 32'd0,       1'b1, 1'b1);
    settle();

    // Widest limits
    write_limit(REG_MIN_SIZE, '0);
    write_limit(REG_MAX_SIZE, '1);
    send_request(32'h0000_0005, 32'h0000_0000, 1'b0, 1'b1);
    send_request(32'h0000_0006, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send_request(32'h0000_0006, 32'hFFFF_FFFF, 1'b1, 1'b0);
    settle();

    // Inverted limits, plus writes to unmapped indexes that must be ignored
    write_limit(REG_MIN_SIZE, 32'd100);
    write_limit(REG_MAX_SIZE, 32'd50);
    write_limit(REG_UNUSED_LO, CFG_DATA_W'($urandom()));
    write_limit(REG_UNUSED_HI, CFG_DATA_W'($urandom()));
    send_request(32'h0000_0007, 32'd75,  1'b1, 1'b0);
    send_request(32'h0000_0007, 32'd100, 1'b0, 1'b1);
    send_request(32'h0000_0006, 32'd0,   1'b0, 1'b0);
    settle();

    write_limit(REG_MIN_SIZE, 32'd16);
    write_limit(REG_MAX_SIZE, 32'd4096);
    for (int n = 0; n < RAND_ITEMS; n++) send_random_request();
    settle();

    send_idle_pct = 88;
    recv_idle_pct = 33;
    write_limit(REG_MIN_SIZE, 32'd1000);
    write_limit(REG_MAX_SIZE, '1);
    for (int n = 0; n < RAND_ITEMS; n++) send_random_request();
    settle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_limit(REG_MIN_SIZE, '0);
    write_limit(REG_MAX_SIZE, '0);
    for (int n = 0; n < RAND_ITEMS; n++) begin
      // long output hold-off while words keep coming, so the input backs up
      if (n == RAND_ITEMS / 2) hold_asked++;
      send_random_request();
    end
    settle();
    repeat (16) @(posedge clk);

    $display("summary: %0d requests, %0d result words checked (ok %0d, not found %0d,",
             requests_sent, sb.checked, sb.per_status[0], sb.per_status[1]);
    $display("summary: exists %0d, invalid %0d, full %0d) over three idle mixes and %0d errors",
             sb.per_status[2], sb.per_status[3], sb.per_status[4], sb.errors);
    if (sb.errors == 0 && sb.replies_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/kst_pkg.sv
hw/rtl/kst_front.sv
hw/rtl/kst_table.sv
hw/rtl/keyed_segment_table.sv
dv/testbench.sv
